// ----- rtl/bia_pkg.sv -----
package bia_pkg;

    localparam int IDX_W      = 8;
    localparam int BIT_IDX_W  = 3;
    localparam int WORD_BITS  = 8;
    localparam int WORD_IDX_W = IDX_W - BIT_IDX_W;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam int RB_W = 8;
    localparam int BC_W = 8;
    localparam int IC_W = 6;
    localparam int FI_W = 6;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic MAP_BLOCK = 1'b0;
    localparam logic MAP_INODE = 1'b1;

    localparam logic [1:0] REG_RESERVED_BLOCKS = 2'd0;
    localparam logic [1:0] REG_BLOCK_COUNT     = 2'd1;
    localparam logic [1:0] REG_INODE_COUNT     = 2'd2;
    localparam logic [1:0] REG_FIRST_INODE     = 2'd3;

    localparam logic [RB_W-1:0] RESERVED_BLOCKS_RST = 8'd0;
    localparam logic [BC_W-1:0] BLOCK_COUNT_RST     = 8'd128;
    localparam logic [IC_W-1:0] INODE_COUNT_RST     = 6'd32;
    localparam logic [FI_W-1:0] FIRST_INODE_RST     = 6'd13;

    typedef struct packed {
        logic                  rd_en;
        logic                  wr_en;
        logic [WORD_IDX_W-1:0] word;
        logic [WORD_BITS-1:0]  wr_data;
    } map_req_t;

endpackage

// ----- rtl/bia_map.sv -----
module bia_map #(
    parameter int ENTRIES = 128
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bia_pkg::map_req_t              req,
    output logic [bia_pkg::WORD_BITS-1:0]  rd_data,
    output logic                           ready
);

    localparam int WORDS = (ENTRIES + bia_pkg::WORD_BITS - 1) / bia_pkg::WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

    logic [bia_pkg::WORD_BITS-1:0] mem [WORDS];

    logic                             clr_busy_reg;
    logic [AW-1:0]                    clr_addr_reg;
    logic [AW+bia_pkg::WORD_IDX_W-1:0] word_ext;
    logic [AW-1:0]                    req_addr;
    logic                             wr_en;
    logic [AW-1:0]                    wr_addr;
    logic [bia_pkg::WORD_BITS-1:0]    wr_data;
    logic [bia_pkg::WORD_BITS-1:0]    rd_data_reg;

    assign word_ext = {{AW{1'b0}}, req.word};
    assign req_addr = word_ext[AW-1:0];
    assign wr_en    = clr_busy_reg | req.wr_en;
    assign wr_addr  = clr_busy_reg ? clr_addr_reg : req_addr;
    assign wr_data  = clr_busy_reg ? '0 : req.wr_data;
    assign rd_data  = rd_data_reg;
    assign ready    = ~clr_busy_reg;

    // After reset every word is cleared once, one word per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            if (clr_addr_reg == AW'(WORDS - 1)) begin
                clr_busy_reg <= 1'b0;
            end else begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req_addr];
        end
    end

    a_no_req_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !(req.rd_en || req.wr_en))
        else $error("map access during clearing pass");

endmodule

// ----- rtl/bitmap_block_inode_allocator_top.sv -----
// First-fit allocator over a block bitmap and an inode bitmap, each kept eight entries to a
// word in its own memory with a free count beside it. An item allocates the lowest free
// entry of the selected map inside its scan window, or writes or reads one bit. One item is
// in work at a time. A read or write passes through an issue step that reads its word,
// a check step that takes the old bit and writes any change back, and a done step that
// presents the result. An allocation stays in the check step, reading one eight-bit word of
// the map per cycle, until it finds a free entry or reaches the last word of its window (up
// to sixteen words for the default block map). A read or write of an index outside the map
// and an allocation with an empty window skip the memory and go from the issue step
// straight to the done step. An item that finishes while the previous result still waits
// for m_ready stays in its last step until that result is taken. After reset the maps are
// cleared one word per cycle; s_ready stays low during that pass.
module bitmap_block_inode_allocator_top #(
    parameter int BLOCK_ENTRIES = 128,
    parameter int INODE_ENTRIES = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bia_pkg::PADDR_W-1:0]   paddr,
    input  logic [bia_pkg::PDATA_W-1:0]   pwdata,
    output logic [bia_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_op,
    input  logic                          s_map_sel,
    input  logic [bia_pkg::IDX_W-1:0]     s_entry_index,
    input  logic                          s_bit_value,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bia_pkg::IDX_W-1:0]     m_alloc_index,
    output logic                          m_bit_out,
    output logic [bia_pkg::IDX_W-1:0]     m_free_left,
    output logic                          m_found
);

    localparam int IW  = bia_pkg::IDX_W;
    localparam int BW  = bia_pkg::BIT_IDX_W;
    localparam int WW  = bia_pkg::WORD_IDX_W;
    localparam int DW  = bia_pkg::WORD_BITS;

    localparam int BLK_CNT_W = $clog2(BLOCK_ENTRIES + 1);
    localparam int INO_CNT_W = $clog2(INODE_ENTRIES + 1);
    localparam int BLK_CAP   = (BLOCK_ENTRIES < 255) ? BLOCK_ENTRIES : 255;
    localparam int INO_CAP   = (INODE_ENTRIES < 63) ? INODE_ENTRIES : 63;
    localparam int INO_IDX_CAP = (INODE_ENTRIES < 255) ? INODE_ENTRIES : 255;
    localparam logic [IW-1:0]            BLK_CAP_V = IW'(BLK_CAP);
    localparam logic [bia_pkg::IC_W-1:0] INO_CAP_V = bia_pkg::IC_W'(INO_CAP);
    localparam logic [IW-1:0]            INO_IDX_V = IW'(INO_IDX_CAP);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_CHECK,
        S_DONE
    } state_t;

    state_t state_reg;

    logic [bia_pkg::RB_W-1:0] reserved_blocks_reg;
    logic [bia_pkg::BC_W-1:0] block_count_reg;
    logic [bia_pkg::IC_W-1:0] inode_count_reg;
    logic [bia_pkg::FI_W-1:0] first_inode_reg;

    logic [BLK_CNT_W-1:0] blk_free_reg;
    logic [INO_CNT_W-1:0] ino_free_reg;

    logic [1:0]    op_reg;
    logic          sel_reg;
    logic [IW-1:0] idx_reg;
    logic          val_reg;
    logic [WW-1:0] cur_word_reg;

    logic [IW-1:0] res_alloc_reg;
    logic          res_bit_reg;
    logic          res_found_reg;

    logic          m_valid_reg;
    logic [IW-1:0] m_alloc_index_reg;
    logic          m_bit_out_reg;
    logic [IW-1:0] m_free_left_reg;
    logic          m_found_reg;

    logic cfg_wr;
    logic is_alloc;
    logic is_write;

    logic [IW-1:0]            blk_hi;
    logic [bia_pkg::IC_W-1:0] ino_hi;
    logic [bia_pkg::FI_W-1:0] ino_lo;
    logic [IW:0]              win_lo;
    logic [IW-1:0]            win_hi;
    logic                     win_empty;
    logic [IW-1:0]            lo_pos;
    logic [IW-1:0]            hi_pos;
    logic [WW-1:0]            start_word;
    logic [WW-1:0]            last_word;
    logic                     idx_ok;
    logic [IW-1:0]            idx_pos;
    logic                     go_mem;

    logic [DW-1:0] blk_rd;
    logic [DW-1:0] ino_rd;
    logic [DW-1:0] rd_word;
    logic [DW-1:0] free_mask;
    logic          hit;
    logic [BW-1:0] first_free;
    logic [IW-1:0] hit_index;
    logic          old_bit;
    logic          blk_ready;
    logic          ino_ready;

    logic chk_dec;
    logic chk_inc;

    logic [BLK_CNT_W+IW-1:0] blk_free_ext;
    logic [INO_CNT_W+IW-1:0] ino_free_ext;
    logic [IW-1:0]           free_sel;

    bia_pkg::map_req_t mreq;
    bia_pkg::map_req_t blk_req;
    bia_pkg::map_req_t ino_req;

    assign cfg_wr   = psel & penable & pwrite & pready;
    assign pready   = 1'b1;
    assign is_alloc = (op_reg == bia_pkg::OP_ALLOC);
    assign is_write = (op_reg == bia_pkg::OP_WRITE);

    always_comb begin
        unique case (paddr[3:2])
            bia_pkg::REG_RESERVED_BLOCKS: prdata = bia_pkg::PDATA_W'(reserved_blocks_reg);
            bia_pkg::REG_BLOCK_COUNT:     prdata = bia_pkg::PDATA_W'(block_count_reg);
            bia_pkg::REG_INODE_COUNT:     prdata = bia_pkg::PDATA_W'(inode_count_reg);
            bia_pkg::REG_FIRST_INODE:     prdata = bia_pkg::PDATA_W'(first_inode_reg);
            default:                      prdata = '0;
        endcase
    end

    // Scan window of the selected map, clipped to the map size.
    assign blk_hi     = (block_count_reg < BLK_CAP_V) ? block_count_reg : BLK_CAP_V;
    assign ino_hi     = (inode_count_reg < INO_CAP_V) ? inode_count_reg : INO_CAP_V;
    assign ino_lo     = (first_inode_reg == '0) ? bia_pkg::FI_W'(1) : first_inode_reg;
    assign win_lo     = (sel_reg == bia_pkg::MAP_INODE) ? (IW+1)'(ino_lo)
                                                        : (IW+1)'(reserved_blocks_reg) + 1'b1;
    assign win_hi     = (sel_reg == bia_pkg::MAP_INODE) ? IW'(ino_hi) : blk_hi;
    assign win_empty  = win_lo > {1'b0, win_hi};
    assign lo_pos     = IW'(win_lo - 1'b1);
    assign hi_pos     = win_hi - 1'b1;
    assign start_word = lo_pos[IW-1:BW];
    assign last_word  = hi_pos[IW-1:BW];

    assign idx_ok  = (idx_reg != '0) &&
                     ((sel_reg == bia_pkg::MAP_INODE) ? (idx_reg <= INO_IDX_V)
                                                      : (idx_reg <= BLK_CAP_V));
    assign idx_pos = idx_reg - 1'b1;
    assign go_mem  = is_alloc ? !win_empty : idx_ok;

    assign rd_word = (sel_reg == bia_pkg::MAP_INODE) ? ino_rd : blk_rd;
    assign old_bit = rd_word[idx_pos[BW-1:0]];

    always_comb begin
        logic [IW-1:0] pos;
        pos        = '0;
        free_mask  = '0;
        first_free = '0;
        for (int b = 0; b < DW; b++) begin
            pos          = {cur_word_reg, BW'(b)};
            free_mask[b] = (pos >= lo_pos) && (pos <= hi_pos) && !rd_word[b];
        end
        for (int b = DW - 1; b >= 0; b--) begin
            if (free_mask[b]) begin
                first_free = BW'(b);
            end
        end
    end

    assign hit       = |free_mask;
    assign hit_index = {cur_word_reg, first_free} + 1'b1;

    assign chk_dec = (state_reg == S_CHECK) &&
                     ((is_alloc && hit) || (is_write && !old_bit && val_reg));
    assign chk_inc = (state_reg == S_CHECK) && is_write && old_bit && !val_reg;

    always_comb begin
        mreq = '0;
        unique case (state_reg)
            S_ISSUE: begin
                if (go_mem) begin
                    mreq.rd_en = 1'b1;
                    mreq.word  = is_alloc ? start_word : idx_pos[IW-1:BW];
                end
            end
            S_CHECK: begin
                if (is_alloc) begin
                    if (hit) begin
                        mreq.wr_en   = 1'b1;
                        mreq.word    = cur_word_reg;
                        mreq.wr_data = rd_word | (DW'(1) << first_free);
                    end else if (cur_word_reg != last_word) begin
                        mreq.rd_en = 1'b1;
                        mreq.word  = cur_word_reg + 1'b1;
                    end
                end else if (is_write && (old_bit != val_reg)) begin
                    mreq.wr_en   = 1'b1;
                    mreq.word    = cur_word_reg;
                    mreq.wr_data = rd_word ^ (DW'(1) << idx_pos[BW-1:0]);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        blk_req       = mreq;
        ino_req       = mreq;
        blk_req.rd_en = mreq.rd_en & (sel_reg == bia_pkg::MAP_BLOCK);
        blk_req.wr_en = mreq.wr_en & (sel_reg == bia_pkg::MAP_BLOCK);
        ino_req.rd_en = mreq.rd_en & (sel_reg == bia_pkg::MAP_INODE);
        ino_req.wr_en = mreq.wr_en & (sel_reg == bia_pkg::MAP_INODE);
    end

    bia_map #(
        .ENTRIES (BLOCK_ENTRIES)
    ) u_blk_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (blk_req),
        .rd_data (blk_rd),
        .ready   (blk_ready)
    );

    bia_map #(
        .ENTRIES (INODE_ENTRIES)
    ) u_ino_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ino_req),
        .rd_data (ino_rd),
        .ready   (ino_ready)
    );

    assign blk_free_ext = {{IW{1'b0}}, blk_free_reg};
    assign ino_free_ext = {{IW{1'b0}}, ino_free_reg};
    assign free_sel     = (sel_reg == bia_pkg::MAP_INODE) ? ino_free_ext[IW-1:0]
                                                          : blk_free_ext[IW-1:0];

    assign s_ready = (state_reg == S_IDLE) && blk_ready && ino_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= S_IDLE;
            m_valid_reg         <= 1'b0;
            blk_free_reg        <= BLK_CNT_W'(BLOCK_ENTRIES);
            ino_free_reg        <= INO_CNT_W'(INODE_ENTRIES);
            reserved_blocks_reg <= bia_pkg::RESERVED_BLOCKS_RST;
            block_count_reg     <= bia_pkg::BLOCK_COUNT_RST;
            inode_count_reg     <= bia_pkg::INODE_COUNT_RST;
            first_inode_reg     <= bia_pkg::FIRST_INODE_RST;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    bia_pkg::REG_RESERVED_BLOCKS: reserved_blocks_reg <= pwdata[bia_pkg::RB_W-1:0];
                    bia_pkg::REG_BLOCK_COUNT:     block_count_reg     <= pwdata[bia_pkg::BC_W-1:0];
                    bia_pkg::REG_INODE_COUNT:     inode_count_reg     <= pwdata[bia_pkg::IC_W-1:0];
                    bia_pkg::REG_FIRST_INODE:     first_inode_reg     <= pwdata[bia_pkg::FI_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (m_valid_reg && m_ready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end

            if (sel_reg == bia_pkg::MAP_INODE) begin
                if (chk_dec) begin
                    ino_free_reg <= ino_free_reg - 1'b1;
                end else if (chk_inc) begin
                    ino_free_reg <= ino_free_reg + 1'b1;
                end
            end else begin
                if (chk_dec) begin
                    blk_free_reg <= blk_free_reg - 1'b1;
                end else if (chk_inc) begin
                    blk_free_reg <= blk_free_reg + 1'b1;
                end
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        op_reg        <= s_op;
                        sel_reg       <= s_map_sel;
                        idx_reg       <= s_entry_index;
                        val_reg       <= s_bit_value;
                        res_alloc_reg <= '0;
                        res_bit_reg   <= 1'b0;
                        res_found_reg <= 1'b0;
                        state_reg     <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    cur_word_reg <= is_alloc ? start_word : idx_pos[IW-1:BW];
                    state_reg    <= go_mem ? S_CHECK : S_DONE;
                end
                S_CHECK: begin
                    if (is_alloc) begin
                        if (hit) begin
                            res_alloc_reg <= hit_index;
                            res_found_reg <= 1'b1;
                            state_reg     <= S_DONE;
                        end else if (cur_word_reg == last_word) begin
                            state_reg <= S_DONE;
                        end else begin
                            cur_word_reg <= cur_word_reg + 1'b1;
                        end
                    end else begin
                        res_bit_reg <= old_bit;
                        state_reg   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_alloc_index_reg <= res_alloc_reg;
                        m_bit_out_reg     <= res_bit_reg;
                        m_found_reg       <= res_found_reg;
                        m_free_left_reg   <= free_sel;
                        m_valid_reg       <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_alloc_index = m_alloc_index_reg;
    assign m_bit_out     = m_bit_out_reg;
    assign m_free_left   = m_free_left_reg;
    assign m_found       = m_found_reg;

    a_rd_wr_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mreq.rd_en && mreq.wr_en))
        else $error("map read and write in the same cycle");

    a_found_matches_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_found == (m_alloc_index != '0)))
        else $error("found flag disagrees with allocated index");

    a_free_within_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        (blk_free_reg <= BLK_CNT_W'(BLOCK_ENTRIES)) &&
        (ino_free_reg <= INO_CNT_W'(INODE_ENTRIES)))
        else $error("free count above map capacity");

    a_count_changes_in_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_CHECK) |=> ($stable(blk_free_reg) && $stable(ino_free_reg)))
        else $error("free count changed outside the update step");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_DONE))
        else $error("result issued without a finished item");

endmodule

// ----- tb/bitmap_alloc_result_checker.sv -----
module bitmap_alloc_result_checker #(
    parameter int BLOCK_N = 128,
    parameter int INODE_N = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bia_pkg::PADDR_W-1:0]   paddr,
    input  logic [bia_pkg::PDATA_W-1:0]   pwdata,
    input  logic [bia_pkg::PDATA_W-1:0]   prdata,
    input  logic                          pready,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [1:0]                    s_op,
    input  logic                          s_map_sel,
    input  logic [bia_pkg::IDX_W-1:0]     s_entry_index,
    input  logic                          s_bit_value,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [bia_pkg::IDX_W-1:0]     m_alloc_index,
    input  logic                          m_bit_out,
    input  logic [bia_pkg::IDX_W-1:0]     m_free_left,
    input  logic                          m_found,
    output int                            mismatches,
    output int                            outstanding
);
    import bia_pkg::*;

    typedef struct packed {
        logic [7:0] alloc_index;
        logic       bit_out;
        logic [7:0] free_left;
        logic       found;
    } map_result_t;

    logic [RB_W-1:0] rsv_blocks;
    logic [BC_W-1:0] blk_count;
    logic [IC_W-1:0] ino_count;
    logic [FI_W-1:0] first_ino;

    logic blk_map [1:BLOCK_N];
    logic ino_map [1:INODE_N];
    int   free_blocks;
    int   free_inodes;

    map_result_t pending_results [$];
    map_result_t got;
    map_result_t want;

    initial begin
        mismatches = 0;
        outstanding = 0;
    end

    task automatic note_error(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s", msg);
        end
    endtask

    function automatic logic map_bit(input logic sel, input int idx);
        if (idx < 1) return 1'b0;
        if (sel == MAP_BLOCK) return (idx <= BLOCK_N) ? blk_map[idx] : 1'b0;
        return (idx <= INODE_N) ? ino_map[idx] : 1'b0;
    endfunction

    function automatic void mark_entry(input logic sel, input int idx, input logic val);
        if (sel == MAP_BLOCK) begin
            if (idx >= 1 && idx <= BLOCK_N && blk_map[idx] != val) begin
                blk_map[idx] = val;
                free_blocks += val ? -1 : 1;
            end
        end else begin
            if (idx >= 1 && idx <= INODE_N && ino_map[idx] != val) begin
                ino_map[idx] = val;
                free_inodes += val ? -1 : 1;
            end
        end
    endfunction

    function automatic map_result_t next_map_result(input logic [1:0] op, input logic sel,
                                                     input logic [7:0] idx, input logic val);
        map_result_t r;
        int lo;
        int hi;
        int i;
        r = '0;
        case (op)
            OP_ALLOC: begin
                if (sel == MAP_BLOCK) begin
                    lo = int'(rsv_blocks) + 1;
                    hi = (int'(blk_count) < BLOCK_N) ? int'(blk_count) : BLOCK_N;
                end else begin
                    lo = (first_ino == '0) ? 1 : int'(first_ino);
                    hi = (int'(ino_count) < INODE_N) ? int'(ino_count) : INODE_N;
                end
                for (i = lo; i <= hi && !r.found; i++) begin
                    if (!map_bit(sel, i)) begin
                        mark_entry(sel, i, 1'b1);
                        r.alloc_index = i[7:0];
                        r.found = 1'b1;
                    end
                end
            end
            OP_WRITE: begin
                r.bit_out = map_bit(sel, int'(idx));
                mark_entry(sel, int'(idx), val);
            end
            default: begin
                r.bit_out = map_bit(sel, int'(idx));
            end
        endcase
        r.free_left = (sel == MAP_BLOCK) ? free_blocks[7:0] : free_inodes[7:0];
        return r;
    endfunction

    function automatic logic [PDATA_W-1:0] reg_value(input logic [1:0] ridx);
        case (ridx)
            REG_RESERVED_BLOCKS: return PDATA_W'(rsv_blocks);
            REG_BLOCK_COUNT:     return PDATA_W'(blk_count);
            REG_INODE_COUNT:     return PDATA_W'(ino_count);
            default:             return PDATA_W'(first_ino);
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            rsv_blocks = RESERVED_BLOCKS_RST;
            blk_count = BLOCK_COUNT_RST;
            ino_count = INODE_COUNT_RST;
            first_ino = FIRST_INODE_RST;
            for (int i = 1; i <= BLOCK_N; i++) blk_map[i] = 1'b0;
            for (int i = 1; i <= INODE_N; i++) ino_map[i] = 1'b0;
            free_blocks = BLOCK_N;
            free_inodes = INODE_N;
            pending_results.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[3:2])
                        REG_RESERVED_BLOCKS: rsv_blocks = pwdata[RB_W-1:0];
                        REG_BLOCK_COUNT:     blk_count = pwdata[BC_W-1:0];
                        REG_INODE_COUNT:     ino_count = pwdata[IC_W-1:0];
                        default:             first_ino = pwdata[FI_W-1:0];
                    endcase
                end else if (prdata !== reg_value(paddr[3:2])) begin
                    note_error($sformatf("Register %0d read back %0h, expected %0h.",
                                         paddr[3:2], prdata, reg_value(paddr[3:2])));
                end
            end
            if (s_valid && s_ready) begin
                pending_results.push_back(next_map_result(s_op, s_map_sel, s_entry_index,
                                                          s_bit_value));
            end
            if (m_valid && m_ready) begin
                got = {m_alloc_index, m_bit_out, m_free_left, m_found};
                if (pending_results.size() == 0) begin
                    note_error($sformatf("Result item with none expected: alloc_index=%0d bit_out=%0d free_left=%0d found=%0d.",
                                         got.alloc_index, got.bit_out, got.free_left, got.found));
                end else begin
                    want = pending_results.pop_front();
                    if (got.alloc_index !== want.alloc_index || got.bit_out !== want.bit_out ||
                        got.free_left !== want.free_left || got.found !== want.found) begin
                        note_error($sformatf("Result mismatch: expected alloc_index=%0d bit_out=%0d free_left=%0d found=%0d, got alloc_index=%0d bit_out=%0d free_left=%0d found=%0d.",
                                             want.alloc_index, want.bit_out, want.free_left,
                                             want.found, got.alloc_index, got.bit_out,
                                             got.free_left, got.found));
                    end
                end
            end
        end
        outstanding = pending_results.size();
    end

endmodule

// ----- tb/bitmap_block_inode_allocator_top_test.sv -----
module bitmap_block_inode_allocator_top_test;
    import bia_pkg::*;

    localparam int BLOCK_N = 128;
    localparam int INODE_N = 32;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 210;
    localparam logic [1:0] OP_SPARE = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [1:0]          s_op = OP_READ;
    logic                s_map_sel = MAP_BLOCK;
    logic [IDX_W-1:0]    s_entry_index = '0;
    logic                s_bit_value = 1'b0;

    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [IDX_W-1:0]    m_alloc_index;
    logic                m_bit_out;
    logic [IDX_W-1:0]    m_free_left;
    logic                m_found;

    int mismatches;
    int outstanding;
    int cycles = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;

    int win_rsv [PHASES] = '{0, 120, 128, 0, 255, 60, 0, 0};
    int win_bc  [PHASES] = '{128, 128, 255, 0, 255, 70, 0, 0};
    int win_ic  [PHASES] = '{32, 32, 63, 0, 63, 20, 0, 0};
    int win_fi  [PHASES] = '{13, 30, 0, 1, 63, 10, 0, 0};

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    bitmap_block_inode_allocator_top #(
        .BLOCK_ENTRIES(BLOCK_N),
        .INODE_ENTRIES(INODE_N)
    ) uut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_map_sel(s_map_sel),
        .s_entry_index(s_entry_index), .s_bit_value(s_bit_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_alloc_index(m_alloc_index),
        .m_bit_out(m_bit_out), .m_free_left(m_free_left), .m_found(m_found)
    );

    bitmap_alloc_result_checker #(
        .BLOCK_N(BLOCK_N),
        .INODE_N(INODE_N)
    ) results_chk (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_map_sel(s_map_sel),
        .s_entry_index(s_entry_index), .s_bit_value(s_bit_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_alloc_index(m_alloc_index),
        .m_bit_out(m_bit_out), .m_free_left(m_free_left), .m_found(m_found),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] op, input logic sel, input logic [7:0] idx,
                             input logic val);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_op = op;
        s_map_sel = sel;
        s_entry_index = idx;
        s_bit_value = val;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [1:0] ridx, input logic [31:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = wr;
        paddr = {ridx, 2'b00};
        pwdata = data;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic wait_idle();
        s_valid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (25) @(negedge aclk);
    endtask

    task automatic set_window(input int rsv, input int bc, input int ic, input int fi);
        int vals [4];
        logic [31:0] wdata;
        vals = '{rsv, bc, ic, fi};
        wait_idle();
        for (int r = 0; r < 4; r++) begin
            wdata = $urandom;
            wdata[7:0] = vals[r][7:0];
            apb_access(1'b1, r[1:0], wdata);
        end
        for (int r = 0; r < 4; r++) begin
            apb_access(1'b0, r[1:0], '0);
        end
    endtask

    task automatic run_random(input int count);
        logic [1:0] op;
        logic sel;
        logic [7:0] idx;
        int roll;
        int size;
        repeat (count) begin
            sel = 1'($urandom_range(1));
            size = (sel == MAP_BLOCK) ? BLOCK_N : INODE_N;
            roll = $urandom_range(99);
            if (roll < 40) op = OP_ALLOC;
            else if (roll < 70) op = OP_WRITE;
            else if (roll < 92) op = OP_READ;
            else op = OP_SPARE;
            roll = $urandom_range(19);
            if (roll == 0) idx = 8'd0;
            else if (roll == 1) idx = 8'(size + 1);
            else if (roll == 2) idx = 8'($urandom_range(255));
            else idx = 8'($urandom_range(size, 1));
            send_item(op, sel, idx, $urandom_range(99) < 40);
        end
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        send_item(OP_READ, MAP_BLOCK, 8'd1, 1'b0);
        send_item(OP_READ, MAP_BLOCK, 8'd128, 1'b1);
        send_item(OP_READ, MAP_BLOCK, 8'd0, 1'b0);
        send_item(OP_READ, MAP_BLOCK, 8'd129, 1'b0);
        send_item(OP_READ, MAP_BLOCK, 8'd255, 1'b1);
        send_item(OP_READ, MAP_INODE, 8'd32, 1'b0);
        send_item(OP_READ, MAP_INODE, 8'd33, 1'b0);
        send_item(OP_ALLOC, MAP_BLOCK, 8'd0, 1'b0);
        send_item(OP_ALLOC, MAP_INODE, 8'd255, 1'b1);
        send_item(OP_WRITE, MAP_BLOCK, 8'd128, 1'b1);
        send_item(OP_WRITE, MAP_BLOCK, 8'd128, 1'b1);
        send_item(OP_WRITE, MAP_BLOCK, 8'd128, 1'b0);
        send_item(OP_WRITE, MAP_BLOCK, 8'd0, 1'b1);
        send_item(OP_WRITE, MAP_BLOCK, 8'd200, 1'b1);
        send_item(OP_WRITE, MAP_INODE, 8'd1, 1'b1);
        send_item(OP_WRITE, MAP_INODE, 8'd33, 1'b1);
        send_item(OP_WRITE, MAP_INODE, 8'd0, 1'b0);
        send_item(OP_SPARE, MAP_INODE, 8'd1, 1'b0);
        send_item(OP_SPARE, MAP_BLOCK, 8'd129, 1'b1);
        send_item(OP_READ, MAP_BLOCK, 8'd1, 1'b0);
        send_item(OP_ALLOC, MAP_BLOCK, 8'd85, 1'b1);
        send_item(OP_ALLOC, MAP_INODE, 8'd170, 1'b0);

        win_rsv[5] = $urandom_range(255);
        win_bc[5] = $urandom_range(255);
        win_ic[5] = $urandom_range(63);
        win_fi[5] = $urandom_range(63);
        win_rsv[7] = $urandom_range(130);
        win_bc[7] = $urandom_range(130);
        win_ic[7] = $urandom_range(40);
        win_fi[7] = $urandom_range(40);

        for (int p = 0; p < PHASES; p++) begin
            set_window(win_rsv[p], win_bc[p], win_ic[p], win_fi[p]);
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 87; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 87; end
                default: begin src_idle_pct = 18; snk_stall_pct = 18; end
            endcase
            run_random(PHASE_ITEMS);
        end

        wait_idle();
        if (mismatches == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
